@@ hdl/mtc_pkg.sv @@
// Shared types, widths and register codes for the missing-tooth crank decoder.
// No dependencies; imported by mtc_avg, missing_tooth_crank_decoder and the bench.
package mtc_pkg;

  // Averaging window is a power of two so the mean is a plain shift.
  localparam int AVG_LOG2     = 3;
  localparam int AVG_DEPTH    = 1 << AVG_LOG2;
  localparam int PERIOD_BITS  = 16;
  localparam int SUM_BITS     = PERIOD_BITS + AVG_LOG2;
  localparam int TOOTH_BITS   = 8;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [PERIOD_BITS-1:0]  period_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [AVG_LOG2-1:0]     slot_t;
  typedef logic [TOOTH_BITS-1:0]   tooth_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_TEETH_LIMIT = 3'd0;
  localparam cfg_idx_t CFG_FIRE_A      = 3'd1;
  localparam cfg_idx_t CFG_FIRE_B      = 3'd2;
  localparam cfg_idx_t CFG_FIRE_C      = 3'd3;
  localparam cfg_idx_t CFG_FIRE_D      = 3'd4;

  // Reset values of the configuration registers
  localparam tooth_t RST_TEETH_LIMIT = 8'd60;
  localparam tooth_t RST_FIRE_A      = 8'd10;
  localparam tooth_t RST_FIRE_B      = 8'd25;
  localparam tooth_t RST_FIRE_C      = 8'd40;
  localparam tooth_t RST_FIRE_D      = 8'd55;

endpackage

@@ hdl/mtc_avg.sv @@
// Period ring with running sum and registered window average.
// Depends on mtc_pkg.
module mtc_avg
  import mtc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd,       // one period enters the ring
  input  period_t period,
  output period_t avg,       // average held before this update
  output period_t mean_nxt   // average once this period is in
);

  period_t ring_r [AVG_DEPTH];
  sum_t    sum_r;
  sum_t    sum_nxt;
  slot_t   slot_r;
  period_t avg_r;
  period_t oldest;
  sum_t    ring_total;

  always_comb begin
    oldest   = ring_r[slot_r];
    sum_nxt  = sum_r - sum_t'(oldest) + sum_t'(period);
    mean_nxt = sum_nxt[SUM_BITS-1:AVG_LOG2];
  end

  assign avg = avg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      sum_r  <= '0;
      slot_r <= slot_t'(AVG_DEPTH - 1);
      avg_r  <= '0;
    end else if (upd) begin
      ring_r[slot_r] <= period;
      sum_r          <= sum_nxt;
      slot_r         <= slot_r + 1'b1;
      avg_r          <= mean_nxt;
    end
  end

  // Full sum of the ring, only for checking the running sum.
  always_comb begin
    ring_total = '0;
    for (int i = 0; i < AVG_DEPTH; i++) begin
      ring_total = ring_total + sum_t'(ring_r[i]);
    end
  end

  a_sum_tracks_ring: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r == ring_total)
    else $error("running sum differs from ring contents");

  a_avg_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r == sum_r[SUM_BITS-1:AVG_LOG2])
    else $error("average register out of step with sum");

  a_upd_moves_slot: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> slot_r == $past(slot_r) + 1'b1)
    else $error("write slot did not advance on update");

endmodule

@@ hdl/missing_tooth_crank_decoder.sv @@
// Missing-tooth crank decoder: accepts one tooth period per clock (valid/ready)
// while out_ready holds, and returns one result per period through the input
// register, then the result register. The ring update uses a running sum, so
// each period costs one subtract/add and a shift; the tooth counter and gap
// compare sit beside it in the same stage. Sustained rate is one period per
// cycle while out_ready holds. After reset the ring is zero, so nonzero periods
// read as gaps until the average builds up. Depends on mtc_pkg and mtc_avg.
module missing_tooth_crank_decoder
  import mtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  period_t  in_tooth_period,
  output logic     out_valid,
  input  logic     out_ready,
  output tooth_t   out_tooth_index,
  output logic     out_gap_seen,
  output logic     out_fire,
  output period_t  out_mean_period,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  tooth_t   cfg_data
);

  tooth_t  teeth_limit_r;
  tooth_t  fire_a_r;
  tooth_t  fire_b_r;
  tooth_t  fire_c_r;
  tooth_t  fire_d_r;

  logic    s1_valid_r;
  period_t s1_period_r;
  logic    s1_adv;

  tooth_t  cnt_r;
  tooth_t  cnt_inc;
  tooth_t  cnt_gap;
  tooth_t  cnt_nxt;
  logic    gap;
  logic    fire;
  period_t avg;
  period_t mean_nxt;

  logic    out_valid_r;
  tooth_t  out_index_r;
  logic    out_gap_r;
  logic    out_fire_r;
  period_t out_mean_r;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      teeth_limit_r <= RST_TEETH_LIMIT;
      fire_a_r      <= RST_FIRE_A;
      fire_b_r      <= RST_FIRE_B;
      fire_c_r      <= RST_FIRE_C;
      fire_d_r      <= RST_FIRE_D;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEETH_LIMIT: teeth_limit_r <= cfg_data;
        CFG_FIRE_A:      fire_a_r      <= cfg_data;
        CFG_FIRE_B:      fire_b_r      <= cfg_data;
        CFG_FIRE_C:      fire_c_r      <= cfg_data;
        CFG_FIRE_D:      fire_d_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_period_r <= in_tooth_period;
    end
  end

  mtc_avg u_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (s1_adv),
    .period   (s1_period_r),
    .avg      (avg),
    .mean_nxt (mean_nxt)
  );

  // Gap test against the average held before this edge, then wrap and match
  always_comb begin
    gap     = {1'b0, s1_period_r} > {avg, 1'b0};
    cnt_inc = cnt_r + 1'b1;
    cnt_gap = gap ? '0 : cnt_inc;
    cnt_nxt = (cnt_gap > teeth_limit_r) ? '0 : cnt_gap;
    fire    = (cnt_nxt == fire_a_r) || (cnt_nxt == fire_b_r) ||
              (cnt_nxt == fire_c_r) || (cnt_nxt == fire_d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (s1_adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_index_r <= cnt_nxt;
      out_gap_r   <= gap;
      out_fire_r  <= fire;
      out_mean_r  <= mean_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tooth_index = out_index_r;
  assign out_gap_seen    = out_gap_r;
  assign out_fire        = out_fire_r;
  assign out_mean_period = out_mean_r;

  a_gap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_gap_r |-> out_index_r == '0)
    else $error("gap result with nonzero tooth index");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result transfer lost between stages");

  a_count_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> cnt_r == out_index_r)
    else $error("tooth counter differs from reported index");

endmodule

@@ bench/missing_tooth_crank_decoder_tb.sv @@
// Self-checking bench for missing_tooth_crank_decoder: directed table, then phased
// random trigger-wheel traffic, compared against an in-bench decoder model.
// Depends on mtc_pkg and the decoder RTL (hdl/).
module missing_tooth_crank_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 64;
  localparam int PHASES         = 8;
  localparam int DRAIN_CYCLES   = 8;

  // indexes past the last register, writes there must be dropped
  localparam cfg_idx_t CFG_SPARE_LO = CFG_FIRE_D + 1'b1;
  localparam cfg_idx_t CFG_SPARE_HI = '1;

  typedef struct packed {
    tooth_t  tooth_index;
    logic    gap_seen;
    logic    fire;
    period_t mean_period;
  } crank_result_t;

  typedef enum logic {ROW_EDGE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    cfg_idx_t      idx;
    tooth_t        val;
    period_t       period;
    bit            typed;
    crank_result_t want;
  } dir_row_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  period_t  in_tooth_period = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tooth_t   out_tooth_index;
  logic     out_gap_seen;
  logic     out_fire;
  period_t  out_mean_period;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_TEETH_LIMIT;
  tooth_t   cfg_data = '0;

  missing_tooth_crank_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_tooth_period (in_tooth_period),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tooth_index (out_tooth_index),
    .out_gap_seen    (out_gap_seen),
    .out_fire        (out_fire),
    .out_mean_period (out_mean_period),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder model state
  period_t ring_q [AVG_DEPTH];
  sum_t    ring_total;
  slot_t   next_slot;
  period_t avg_q;
  tooth_t  tooth_cnt;
  tooth_t  teeth_lim;
  tooth_t  fire_q [4];

  crank_result_t expected_q [$];
  dir_row_t      dir_rows [$];

  int err_cnt = 0;
  int n_edges = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_gaps = 0;
  int n_fires = 0;
  int n_held = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic crank_result_t decode_edge(period_t p);
    crank_result_t r;
    logic gap;
    tooth_cnt = tooth_cnt + 1'b1;
    gap = {1'b0, p} > ({1'b0, avg_q} << 1);
    if (gap) tooth_cnt = '0;
    ring_total = ring_total - sum_t'(ring_q[next_slot]) + sum_t'(p);
    ring_q[next_slot] = p;
    next_slot = next_slot + 1'b1;
    avg_q = period_t'(ring_total >> AVG_LOG2);
    // wrap happens before the fire compare
    if (tooth_cnt > teeth_lim) tooth_cnt = '0;
    r.tooth_index = tooth_cnt;
    r.gap_seen    = gap;
    r.fire        = (tooth_cnt == fire_q[0]) || (tooth_cnt == fire_q[1]) ||
                    (tooth_cnt == fire_q[2]) || (tooth_cnt == fire_q[3]);
    r.mean_period = avg_q;
    return r;
  endfunction

  task automatic add_edge(input period_t p);
    dir_row_t row;
    row = '{ROW_EDGE, CFG_TEETH_LIMIT, '0, p, 1'b0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic add_edge_typed(input period_t p, input tooth_t idx, input logic gap,
                                input logic fire, input period_t mean);
    dir_row_t row;
    row = '{ROW_EDGE, CFG_TEETH_LIMIT, '0, p, 1'b1, crank_result_t'({idx, gap, fire, mean})};
    dir_rows.push_back(row);
  endtask

  task automatic add_reg(input cfg_idx_t idx, input tooth_t val);
    dir_row_t row;
    row = '{ROW_REG, idx, val, '0, 1'b0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic set_idle(input idle_mode_t m);
    send_idle_pct = (m == IDLE_SENDER) ? 87 : (m == IDLE_BOTH) ? 16 : 0;
    stall_pct     = (m == IDLE_RECEIVER) ? 87 : (m == IDLE_BOTH) ? 16 : 0;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_period(input period_t p, input bit typed, input crank_result_t want,
                             input bit hold_after);
    crank_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_tooth_period <= period_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tooth_period <= p;
    do @(posedge clk); while (!in_ready);
    pred = decode_edge(p);
    expected_q.push_back(typed ? want : pred);
    n_edges++;
    if (hold_after) hold_left = HOLD_CYCLES;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input tooth_t val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEETH_LIMIT: teeth_lim = val;
      CFG_FIRE_A:      fire_q[0] = val;
      CFG_FIRE_B:      fire_q[1] = val;
      CFG_FIRE_C:      fire_q[2] = val;
      CFG_FIRE_D:      fire_q[3] = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  crank_result_t got_r, want_r;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (in_valid && !in_ready) n_held++;
      if (out_valid && out_ready) begin
        got_r = {out_tooth_index, out_gap_seen, out_fire, out_mean_period};
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: unexpected result, expected none, got index %0d mean %0d",
                   $time, got_r.tooth_index, got_r.mean_period);
        end else begin
          want_r = expected_q.pop_front();
          check_field("tooth_index", want_r.tooth_index, got_r.tooth_index);
          check_field("gap_seen", want_r.gap_seen, got_r.gap_seen);
          check_field("fire", want_r.fire, got_r.fire);
          check_field("mean_period", want_r.mean_period, got_r.mean_period);
          n_checked++;
        end
        if (got_r.gap_seen === 1'b1) n_gaps++;
        if (got_r.fire === 1'b1) n_fires++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int     base;
    int     teeth_left;
    int     wheel_len;
    int     n_items;
    int     noise_pct;
    int     r;
    period_t p;
    tooth_t lim;
    tooth_t fires [4];

    foreach (ring_q[i]) ring_q[i] = '0;
    ring_total = '0;
    next_slot  = slot_t'(AVG_DEPTH - 1);
    avg_q      = '0;
    tooth_cnt  = '0;
    teeth_lim  = RST_TEETH_LIMIT;
    fire_q[0]  = RST_FIRE_A;
    fire_q[1]  = RST_FIRE_B;
    fire_q[2]  = RST_FIRE_C;
    fire_q[3]  = RST_FIRE_D;
    set_idle(IDLE_NONE);

    // start-up: empty ring reads any nonzero period as a gap
    add_edge_typed(16'h0000, 8'd1, 1'b0, 1'b0, 16'd0);
    add_edge_typed(16'hFFFF, 8'd0, 1'b1, 1'b0, 16'd8191);
    add_edge_typed(16'hFFFF, 8'd0, 1'b1, 1'b0, 16'd16383);
    add_edge_typed(16'h0000, 8'd1, 1'b0, 1'b0, 16'd16383);
    add_reg(CFG_FIRE_A, 8'd2);
    add_edge_typed(16'h0000, 8'd2, 1'b0, 1'b1, 16'd16383);
    // wrap first, then fire on the wrapped value
    add_reg(CFG_FIRE_B, 8'd0);
    add_reg(CFG_TEETH_LIMIT, 8'd2);
    add_edge_typed(16'h0000, 8'd0, 1'b0, 1'b1, 16'd16383);
    // limit of zero pins the counter
    add_reg(CFG_TEETH_LIMIT, 8'd0);
    add_edge_typed(16'h0000, 8'd0, 1'b0, 1'b1, 16'd16383);
    add_reg(CFG_SPARE_LO, 8'h37);
    add_reg(CFG_SPARE_LO + 1'b1, 8'h4D);
    add_reg(CFG_SPARE_HI, 8'hFF);
    add_edge_typed(16'h0000, 8'd0, 1'b0, 1'b1, 16'd16383);
    add_reg(CFG_TEETH_LIMIT, 8'd255);
    add_reg(CFG_FIRE_A, 8'd255);
    add_reg(CFG_FIRE_B, 8'd25);
    add_reg(CFG_FIRE_C, 8'd0);
    add_reg(CFG_FIRE_D, 8'd128);
    repeat (AVG_DEPTH) add_edge(16'hFFFF);
    add_edge(16'h0000);
    add_edge(16'h0001);
    add_edge(16'h8000);
    add_edge(16'h7FFF);
    add_edge(16'h5555);
    add_edge(16'hAAAA);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      else
        send_period(dir_rows[i].period, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    end

    for (int k = 0; k < PHASES; k++) begin
      n_items   = (k == 1) ? 400 : 180;
      noise_pct = (k == 1) ? 0 : 8;
      case (k)
        0: begin
          lim = 8'd57;
          wheel_len = 57;
          foreach (fires[j]) fires[j] = tooth_t'($urandom_range(0, 57));
        end
        1: begin
          // long wheel without gaps runs the counter through 255
          lim = 8'd255;
          wheel_len = 300;
          fires = '{8'd0, 8'd255, 8'd128, 8'd200};
        end
        2: begin
          lim = 8'd1;
          wheel_len = 3;
          fires = '{8'd0, 8'd1, 8'd255, 8'd1};
        end
        default: begin
          lim = tooth_t'($urandom_range(1, 255));
          wheel_len = $urandom_range(2, 80);
          foreach (fires[j]) fires[j] = tooth_t'($urandom_range(0, lim));
        end
      endcase
      write_reg(CFG_TEETH_LIMIT, lim);
      write_reg(CFG_FIRE_A, fires[0]);
      write_reg(CFG_FIRE_B, fires[1]);
      write_reg(CFG_FIRE_C, fires[2]);
      write_reg(CFG_FIRE_D, fires[3]);
      write_reg(cfg_idx_t'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                tooth_t'($urandom));
      set_idle(idle_mode_t'(k % 4));
      base = $urandom_range(4, 16000);
      teeth_left = wheel_len;

      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < noise_pct) begin
          case ($urandom_range(0, 3))
            0: p = '0;
            1: p = period_t'($urandom);
            2: p = period_t'($urandom_range(0, 255));
            default: begin
              // cut the wheel short so the next gap comes early
              teeth_left = 0;
              p = period_t'(base);
            end
          endcase
        end else if (teeth_left == 0) begin
          p = period_t'(3 * base + int'($urandom_range(0, base)));
          teeth_left = wheel_len;
          base = base - base / 16 + int'($urandom_range(0, base / 8));
          if (base < 4) base = 4;
          if (base > 16000) base = 16000;
        end else begin
          p = period_t'(base - base / 16 + int'($urandom_range(0, base / 8)));
          teeth_left--;
        end
        if (k == 3 && i == 90) drain();
        send_period(p, 1'b0, '0, (k == 0 && i == 90));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d tooth periods (%0d results checked) through %0d register writes,",
             n_edges, n_checked, n_writes);
    $display("seeing %0d gaps, %0d fire pulses and %0d cycles of input backpressure.",
             n_gaps, n_fires, n_held);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mtc_pkg.sv
hdl/mtc_avg.sv
hdl/missing_tooth_crank_decoder.sv
bench/missing_tooth_crank_decoder_tb.sv
